// ----- sv/jsu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and decode functions for the JSON string unescaper.
// No dependencies; used by json_string_unescape.

package jsu_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] hex_left;
    logic [7:0] code_low;
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
  } step_t;

  // Bit 4 set marks a valid hex digit, low nibble holds its value.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b1, 4'(c - 8'h37)};
    end
    return v;
  endfunction

  function automatic result_t mk_res(logic [7:0] d, kind_t k, logic l);
    result_t r;
    r.data = d;
    r.kind = k;
    r.last = l;
    return r;
  endfunction

  function automatic step_t decode(phase_t ph, logic [1:0] hl, logic [7:0] cl,
                                   logic [7:0] c);
    step_t      s;
    logic [4:0] h;
    logic [7:0] code;
    h    = hex_val(c);
    code = {cl[3:0], h[3:0]};
    s.phase    = ph;
    s.hex_left = hl;
    s.code_low = cl;
    s.n_res    = 2'd0;
    s.res0     = mk_res(CH_NUL, KIND_ERR, 1'b1);
    s.res1     = mk_res(c, KIND_BYTE, 1'b1);
    unique case (ph)
      PH_IDLE: begin
        if (c == CH_QUOTE) begin
          s.phase = PH_BODY;
        end else begin
          s.n_res = 2'd1;
        end
      end
      PH_BODY: begin
        if (c == CH_NUL) begin
          s.n_res = 2'd1;
        end else if (c == CH_QUOTE) begin
          s.phase = PH_IDLE;
          s.n_res = 2'd1;
          s.res0  = mk_res(CH_NUL, KIND_END, 1'b1);
        end else if (c == CH_BSL) begin
          s.phase = PH_ESC;
        end else begin
          s.n_res = 2'd1;
          s.res0  = mk_res(c, KIND_BYTE, 1'b1);
        end
      end
      PH_ESC: begin
        s.phase = PH_BODY;
        s.n_res = 2'd1;
        case (c)
          CH_NUL:   s.res0 = mk_res(CH_NUL, KIND_ERR, 1'b1);
          CH_QUOTE: s.res0 = mk_res(CH_QUOTE, KIND_BYTE, 1'b1);
          CH_BSL:   s.res0 = mk_res(CH_BSL, KIND_BYTE, 1'b1);
          CH_SLASH: s.res0 = mk_res(CH_SLASH, KIND_BYTE, 1'b1);
          CH_B:     s.res0 = mk_res(8'h08, KIND_BYTE, 1'b1);
          CH_F:     s.res0 = mk_res(8'h0c, KIND_BYTE, 1'b1);
          CH_N:     s.res0 = mk_res(8'h0a, KIND_BYTE, 1'b1);
          CH_R:     s.res0 = mk_res(8'h0d, KIND_BYTE, 1'b1);
          CH_T:     s.res0 = mk_res(8'h09, KIND_BYTE, 1'b1);
          CH_U: begin
            s.phase    = PH_HEX;
            s.hex_left = 2'd3;
            s.code_low = 8'h00;
            s.n_res    = 2'd0;
          end
          default: begin
            // unknown escape: pass backslash and the character through
            s.n_res = 2'd2;
            s.res0  = mk_res(CH_BSL, KIND_BYTE, 1'b0);
          end
        endcase
        if (c == CH_NUL) begin
          s.phase    = PH_IDLE;
          s.hex_left = 2'd0;
          s.code_low = 8'h00;
        end
      end
      PH_HEX: begin
        if (!h[4]) begin
          s.n_res = 2'd1;
        end else begin
          s.code_low = code;
          if (hl == 2'd0) begin
            s.phase = PH_BODY;
            s.n_res = 2'd1;
            s.res0  = mk_res(code, KIND_BYTE, 1'b1);
          end else begin
            s.hex_left = hl - 2'd1;
          end
        end
      end
      default: s.phase = PH_IDLE;
    endcase
    // errors drop the string and clear the code state
    if (s.n_res == 2'd1 && s.res0.kind == KIND_ERR) begin
      s.phase    = PH_IDLE;
      s.hex_left = 2'd0;
      s.code_low = 8'h00;
    end
    return s;
  endfunction

endpackage

// ----- sv/json_string_unescape.sv -----
`timescale 1ns / 1ps
// JSON string unescaper top level: decode state and a two-entry result queue.
// Depends on jsu_pkg for types and the byte decode function.
// Results are registered in the result queue; out_ shows the queue head.
// Throughput: one byte per cycle unless in_stall is high; an unknown escape yields
// two results, and in_stall holds a byte until the two-entry result queue has room.
// Reset: synchronous active-low rst_n returns to idle with an empty queue.

module json_string_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);

  jsu_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]       hex_left_r, hex_left_nxt;
  logic [7:0]       code_low_r, code_low_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  jsu_pkg::result_t q_r [2];
  jsu_pkg::result_t q_nxt [2];

  jsu_pkg::step_t   step;
  logic             in_xfer;
  logic             out_xfer;
  logic [1:0]       cnt_pop;

  assign step = jsu_pkg::decode(phase_r, hex_left_r, code_low_r, in_byte);

  // admit a byte only when the queue has room for all its results
  assign in_stall  = ({1'b0, step.n_res} + {1'b0, cnt_r}) > 3'd2;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_xfer  = out_valid && !out_stall;

  assign out_byte  = q_r[0].data;
  assign out_kind  = q_r[0].kind;
  assign out_last  = q_r[0].last;

  always_comb begin
    phase_nxt    = phase_r;
    hex_left_nxt = hex_left_r;
    code_low_nxt = code_low_r;
    q_nxt[0]     = q_r[0];
    q_nxt[1]     = q_r[1];
    cnt_pop      = cnt_r;
    if (out_xfer) begin
      q_nxt[0] = q_r[1];
      cnt_pop  = cnt_r - 2'd1;
    end
    cnt_nxt = cnt_pop;
    if (in_xfer) begin
      phase_nxt    = step.phase;
      hex_left_nxt = step.hex_left;
      code_low_nxt = step.code_low;
      if (step.n_res != 2'd0) begin
        q_nxt[cnt_pop[0]] = step.res0;
      end
      if (step.n_res == 2'd2) begin
        q_nxt[1] = step.res1;
      end
      cnt_nxt = cnt_pop + step.n_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jsu_pkg::PH_IDLE;
      hex_left_r <= 2'd0;
      code_low_r <= 8'h00;
      cnt_r      <= 2'd0;
    end else begin
      phase_r    <= phase_nxt;
      hex_left_r <= hex_left_nxt;
      code_low_r <= code_low_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench for json_string_unescape: directed and random quoted strings,
// checked against an in-bench decoder. Depends on jsu_pkg and the top level.

module tb;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  // decoder state mirrored in the bench
  jsu_pkg::phase_t  dec_phase    = jsu_pkg::PH_IDLE;
  logic [1:0]       dec_hex_left = 2'd0;
  logic [7:0]       dec_code_low = 8'h00;
  jsu_pkg::result_t decoded_q[$];
  jsu_pkg::result_t want_res;

  int errors      = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int gap_max     = 0;
  int hold_request = 0;
  int hold_left   = 0;
  int stall_pct   = 0;
  int pattern_left = 0;

  json_string_unescape i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** json_string_unescape: FAILED **");
    $finish;
  end

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    return c inside {jsu_pkg::CH_NUL, jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL,
                     jsu_pkg::CH_SLASH, jsu_pkg::CH_B, jsu_pkg::CH_F,
                     jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_U};
  endfunction

  task automatic add_decoded(input logic [7:0] d, input jsu_pkg::kind_t k,
                             input logic l);
    jsu_pkg::result_t r;
    r.data = d;
    r.kind = k;
    r.last = l;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic drop_string();
    dec_phase    = jsu_pkg::PH_IDLE;
    dec_hex_left = 2'd0;
    dec_code_low = 8'h00;
    add_decoded(jsu_pkg::CH_NUL, jsu_pkg::KIND_ERR, 1'b1);
  endtask

  // Advance the mirrored decoder by one accepted byte.
  task automatic unescape_step(input logic [7:0] c);
    int h;
    h = hex_nibble(c);
    case (dec_phase)
      jsu_pkg::PH_IDLE: begin
        if (c == jsu_pkg::CH_QUOTE) dec_phase = jsu_pkg::PH_BODY;
        else drop_string();
      end
      jsu_pkg::PH_BODY: begin
        if (c == jsu_pkg::CH_NUL) begin
          drop_string();
        end else if (c == jsu_pkg::CH_QUOTE) begin
          dec_phase = jsu_pkg::PH_IDLE;
          add_decoded(jsu_pkg::CH_NUL, jsu_pkg::KIND_END, 1'b1);
        end else if (c == jsu_pkg::CH_BSL) begin
          dec_phase = jsu_pkg::PH_ESC;
        end else begin
          add_decoded(c, jsu_pkg::KIND_BYTE, 1'b1);
        end
      end
      jsu_pkg::PH_ESC: begin
        dec_phase = jsu_pkg::PH_BODY;
        case (c) inside
          jsu_pkg::CH_NUL: drop_string();
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
            add_decoded(c, jsu_pkg::KIND_BYTE, 1'b1);
          jsu_pkg::CH_B: add_decoded(8'h08, jsu_pkg::KIND_BYTE, 1'b1);
          jsu_pkg::CH_F: add_decoded(8'h0c, jsu_pkg::KIND_BYTE, 1'b1);
          jsu_pkg::CH_N: add_decoded(8'h0a, jsu_pkg::KIND_BYTE, 1'b1);
          jsu_pkg::CH_R: add_decoded(8'h0d, jsu_pkg::KIND_BYTE, 1'b1);
          jsu_pkg::CH_T: add_decoded(8'h09, jsu_pkg::KIND_BYTE, 1'b1);
          jsu_pkg::CH_U: begin
            dec_phase    = jsu_pkg::PH_HEX;
            dec_hex_left = 2'd3;
            dec_code_low = 8'h00;
          end
          default: begin
            add_decoded(jsu_pkg::CH_BSL, jsu_pkg::KIND_BYTE, 1'b0);
            add_decoded(c, jsu_pkg::KIND_BYTE, 1'b1);
          end
        endcase
      end
      default: begin
        if (h < 0) begin
          drop_string();
        end else begin
          dec_code_low = {dec_code_low[3:0], 4'(h)};
          if (dec_hex_left == 2'd0) begin
            dec_phase = jsu_pkg::PH_BODY;
            add_decoded(dec_code_low, jsu_pkg::KIND_BYTE, 1'b1);
          end else begin
            dec_hex_left = dec_hex_left - 2'd1;
          end
        end
      end
    endcase
  endtask

  // Drive one byte and wait for its transfer; gaps fall between bursts.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    unescape_step(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] unknown_escape_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_escape_letter(c));
    return c;
  endfunction

  function automatic logic [7:0] random_hex_digit();
    case ($urandom_range(2))
      0:       return 8'("0" + $urandom_range(9));
      1:       return 8'("a" + $urandom_range(5));
      default: return 8'("A" + $urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] simple_escape_letter();
    case ($urandom_range(7))
      0:       return jsu_pkg::CH_QUOTE;
      1:       return jsu_pkg::CH_BSL;
      2:       return jsu_pkg::CH_SLASH;
      3:       return jsu_pkg::CH_B;
      4:       return jsu_pkg::CH_F;
      5:       return jsu_pkg::CH_N;
      6:       return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  task automatic send_random_string();
    int pick;
    send_byte(jsu_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 12)) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_byte(plain_char());
      end else if (pick < 70) begin
        send_byte(jsu_pkg::CH_BSL);
        send_byte(simple_escape_letter());
      end else if (pick < 85) begin
        send_byte(jsu_pkg::CH_BSL);
        send_byte(jsu_pkg::CH_U);
        repeat (4) send_byte(random_hex_digit());
      end else begin
        send_byte(jsu_pkg::CH_BSL);
        send_byte(unknown_escape_char());
      end
    end
    send_byte(jsu_pkg::CH_QUOTE);
  endtask

  task automatic send_broken_string();
    logic [7:0] bad;
    case ($urandom_range(3))
      0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      1: begin
        send_byte(jsu_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 3)) send_byte(plain_char());
        send_byte(jsu_pkg::CH_NUL);
      end
      2: begin
        send_byte(jsu_pkg::CH_QUOTE);
        send_byte(jsu_pkg::CH_BSL);
        send_byte(jsu_pkg::CH_NUL);
      end
      default: begin
        send_byte(jsu_pkg::CH_QUOTE);
        send_byte(jsu_pkg::CH_BSL);
        send_byte(jsu_pkg::CH_U);
        repeat ($urandom_range(0, 3)) send_byte(random_hex_digit());
        do bad = 8'($urandom_range(0, 255)); while (hex_nibble(bad) >= 0);
        send_byte(bad);
      end
    endcase
    // drop any half-open string so the next one starts from idle
    while (dec_phase != jsu_pkg::PH_IDLE) send_byte(jsu_pkg::CH_NUL);
  endtask

  task automatic test_missing_quote();
    send_text("x");
    send_byte(8'hff);
  endtask

  task automatic test_escapes();
    send_text("\"A");
    send_byte(8'h01);
    send_byte(8'hff);
    send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\\u00Af\"");
  endtask

  task automatic test_unknown_escape();
    send_text("\"\\q\\");
    send_byte(8'hff);
    send_text("\"");
  endtask

  task automatic test_syntax_errors();
    send_text("\"");
    send_byte(jsu_pkg::CH_NUL);
    send_text("\"\\");
    send_byte(jsu_pkg::CH_NUL);
    send_text("\"\\u1");
    send_byte(jsu_pkg::CH_NUL);
    send_text("\"\\u2g");
  endtask

  // Receiver holds off while two-result escapes pile up behind it.
  task automatic test_backpressure();
    gap_max = 0;
    hold_request = 80;
    send_text("\"");
    repeat (12) begin
      send_byte(jsu_pkg::CH_BSL);
      send_byte(unknown_escape_char());
    end
    send_text("ok\"");
  endtask

  task automatic test_random_strings();
    while (items_sent < 550) begin
      case ($urandom_range(4))
        0, 1:    gap_max = 0;
        2:       gap_max = 1;
        3:       gap_max = 3;
        default: gap_max = 8;
      endcase
      if ($urandom_range(99) < 85) send_random_string();
      else send_broken_string();
    end
  endtask

  // Receiver stall: long hold on request, otherwise a random duty that shifts.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 120);
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result byte %02h kind %0d last %0d", $time,
                 out_byte, out_kind, out_last);
        errors++;
      end else begin
        want_res = decoded_q.pop_front();
        if (out_byte !== want_res.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, want_res.data, out_byte);
          errors++;
        end
        if (out_kind !== want_res.kind) begin
          $display("%0t: out_kind expected %0d got %0d", $time, want_res.kind, out_kind);
          errors++;
        end
        if (out_last !== want_res.last) begin
          $display("%0t: out_last expected %0d got %0d", $time, want_res.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_missing_quote();
    test_escapes();
    test_unknown_escape();
    test_syntax_errors();
    test_backpressure();
    test_random_strings();
    in_valid <= 1'b0;
    waited = 0;
    while (decoded_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d results missing, first expected byte %02h kind %0d, got none",
               $time, decoded_q.size(), decoded_q[0].data, decoded_q[0].kind);
      errors++;
    end
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** json_string_unescape: PASSED **");
    end else begin
      $display("** json_string_unescape: FAILED **");
    end
    $finish;
  end

endmodule
